/* hw/rtl/dtx_pkg.sv */
// Shared types, constants and command codes for the dye transmittance to XYZ block.
package dtx_pkg;

   localparam int unsigned CFG_ADDR_W = 2;
   localparam int unsigned CFG_DATA_W = 32;

   localparam logic [CFG_ADDR_W-1:0] REG_BASELINE_ENABLE = 2'd0;
   localparam logic [CFG_ADDR_W-1:0] REG_BASELINE_SCALE  = 2'd1;
   localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_SCALE    = 2'd2;

   localparam logic [15:0] BASELINE_SCALE_RESET = 16'd4096;
   localparam logic [31:0] OUTPUT_SCALE_RESET   = 32'd16777216;

   localparam logic [31:0] Q30_ONE     = 32'd1073741824;
   localparam logic [31:0] LOG2_10_Q30 = 32'd3566893132;
   localparam logic [31:0] LN2_Q30     = 32'd744261118;
   localparam logic [31:0] C2_Q30      = 32'd536870848;
   localparam logic [31:0] C3_Q30      = 32'd178955744;
   localparam logic [31:0] C4_Q30      = 32'd44729236;
   localparam logic [31:0] C5_Q30      = 32'd8913249;
   localparam logic [33:0] FLUSH_D     = 34'd100663296;
   localparam logic [47:0] ACC_MAX     = 48'hFFFF_FFFF_FFFF;
   localparam logic [15:0] T_MAX       = 16'hFFFF;
   localparam logic [31:0] OUT_MAX     = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [15:0] density_y;
      logic [15:0] density_m;
      logic [15:0] density_c;
      logic [15:0] ext_y;
      logic [15:0] ext_m;
      logic [15:0] ext_c;
      logic [15:0] baseline_density;
      logic [15:0] cmf_x;
      logic [15:0] cmf_y;
      logic [15:0] cmf_z;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [31:0] x_out;
      logic [31:0] y_out;
      logic [31:0] z_out;
      logic        saturated;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE = 5'd0,
      OP_LOAD = 5'd1,
      OP_D0   = 5'd2,
      OP_D1   = 5'd3,
      OP_D2   = 5'd4,
      OP_D3   = 5'd5,
      OP_E    = 5'd6,
      OP_G    = 5'd7,
      OP_Q1   = 5'd8,
      OP_Q2   = 5'd9,
      OP_Q3   = 5'd10,
      OP_GG   = 5'd11,
      OP_EX   = 5'd12,
      OP_T    = 5'd13,
      OP_AX   = 5'd14,
      OP_AY   = 5'd15,
      OP_AZ   = 5'd16,
      OP_LX   = 5'd17,
      OP_HX   = 5'd18,
      OP_LY   = 5'd19,
      OP_HY   = 5'd20,
      OP_LZ   = 5'd21,
      OP_HZ   = 5'd22,
      OP_EMIT = 5'd23
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic rsp_busy;
   } sts_type;

endpackage

/* hw/rtl/dtx_ctrl.sv */
// Sequencer for the dye transmittance to XYZ datapath.
module dtx_ctrl import dtx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [22:0] {
      ST_IDLE = 23'h000001,
      ST_D0   = 23'h000002,
      ST_D1   = 23'h000004,
      ST_D2   = 23'h000008,
      ST_D3   = 23'h000010,
      ST_E    = 23'h000020,
      ST_G    = 23'h000040,
      ST_Q1   = 23'h000080,
      ST_Q2   = 23'h000100,
      ST_Q3   = 23'h000200,
      ST_GG   = 23'h000400,
      ST_EX   = 23'h000800,
      ST_T    = 23'h001000,
      ST_AX   = 23'h002000,
      ST_AY   = 23'h004000,
      ST_AZ   = 23'h008000,
      ST_LX   = 23'h010000,
      ST_HX   = 23'h020000,
      ST_LY   = 23'h040000,
      ST_HY   = 23'h080000,
      ST_LZ   = 23'h100000,
      ST_HZ   = 23'h200000,
      ST_OUT  = 23'h400000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_D0;
            end
         end
         ST_D0: begin cmd.op = OP_D0; state_in = ST_D1; end
         ST_D1: begin cmd.op = OP_D1; state_in = ST_D2; end
         ST_D2: begin cmd.op = OP_D2; state_in = ST_D3; end
         ST_D3: begin cmd.op = OP_D3; state_in = ST_E;  end
         ST_E:  begin cmd.op = OP_E;  state_in = ST_G;  end
         ST_G:  begin cmd.op = OP_G;  state_in = ST_Q1; end
         ST_Q1: begin cmd.op = OP_Q1; state_in = ST_Q2; end
         ST_Q2: begin cmd.op = OP_Q2; state_in = ST_Q3; end
         ST_Q3: begin cmd.op = OP_Q3; state_in = ST_GG; end
         ST_GG: begin cmd.op = OP_GG; state_in = ST_EX; end
         ST_EX: begin cmd.op = OP_EX; state_in = ST_T;  end
         ST_T:  begin cmd.op = OP_T;  state_in = ST_AX; end
         ST_AX: begin cmd.op = OP_AX; state_in = ST_AY; end
         ST_AY: begin cmd.op = OP_AY; state_in = ST_AZ; end
         ST_AZ: begin
            cmd.op   = OP_AZ;
            state_in = sts.last ? ST_LX : ST_IDLE;
         end
         ST_LX: begin cmd.op = OP_LX; state_in = ST_HX; end
         ST_HX: begin cmd.op = OP_HX; state_in = ST_LY; end
         ST_LY: begin cmd.op = OP_LY; state_in = ST_HY; end
         ST_HY: begin cmd.op = OP_HY; state_in = ST_LZ; end
         ST_LZ: begin cmd.op = OP_LZ; state_in = ST_HZ; end
         ST_HZ: begin cmd.op = OP_HZ; state_in = ST_OUT; end
         ST_OUT: begin
            if (!sts.rsp_busy) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_D0))
      else $error("accepted beat did not start the sequence");
   a_no_last_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AZ && !sts.last) |=> (state_ff == ST_IDLE))
      else $error("non-final sample did not return to idle");
   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && sts.rsp_busy) |=> (state_ff == ST_OUT))
      else $error("result issued while output register occupied");
`endif

endmodule

/* hw/rtl/dtx_datapath.sv */
// Shared-multiplier datapath: density sum, 10^-D, weighted accumulation, output scaling.
module dtx_datapath import dtx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  logic                  csr_we,
   input  logic [CFG_ADDR_W-1:0] csr_addr,
   input  logic [CFG_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   logic        bl_en_ff;
   logic [15:0] bl_scale_ff;
   logic [31:0] out_scale_ff;

   req_type     in_ff;
   logic [33:0] d_ff, d_in;
   logic [4:0]  n_ff, n_in;
   logic [31:0] f_ff, f_in;
   logic        flush_ff, flush_in;
   logic [30:0] g_ff, g_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] gg_ff, gg_in;
   logic [31:0] e_ff, e_in;
   logic [15:0] t_ff, t_in;
   logic [47:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in, acc_z_ff, acc_z_in;
   logic [55:0] lo_ff, lo_in;
   logic [31:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic        sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod, prod_e, prod_g, prod_q;
   logic [36:0] e32;
   logic [5:0]  sh;
   logic [63:0] t_sum, t_wide;
   logic [48:0] acc_sum;
   logic [47:0] acc_sel;
   logic [79:0] p_full;
   logic [49:0] r_out;
   logic [31:0] r_val;
   logic        r_sat;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      acc_sel = acc_x_ff;
      case (cmd.op)
         OP_D0: begin mul_a = {16'd0, in_ff.density_y}; mul_b = {16'd0, in_ff.ext_y}; end
         OP_D1: begin mul_a = {16'd0, in_ff.density_m}; mul_b = {16'd0, in_ff.ext_m}; end
         OP_D2: begin mul_a = {16'd0, in_ff.density_c}; mul_b = {16'd0, in_ff.ext_c}; end
         OP_D3: begin
            mul_a = {16'd0, bl_scale_ff};
            mul_b = {16'd0, in_ff.baseline_density};
         end
         OP_E:  begin mul_a = {5'd0, d_ff[26:0]}; mul_b = LOG2_10_Q30; end
         OP_G:  begin mul_a = f_ff; mul_b = LN2_Q30; end
         OP_Q1: begin mul_a = C5_Q30; mul_b = {1'b0, g_ff}; end
         OP_Q2, OP_Q3: begin mul_a = q_ff; mul_b = {1'b0, g_ff}; end
         OP_GG: begin mul_a = {1'b0, g_ff}; mul_b = {1'b0, g_ff}; end
         OP_EX: begin mul_a = gg_ff; mul_b = q_ff; end
         OP_AX: begin mul_a = {16'd0, t_ff}; mul_b = {16'd0, in_ff.cmf_x}; end
         OP_AY: begin mul_a = {16'd0, t_ff}; mul_b = {16'd0, in_ff.cmf_y}; acc_sel = acc_y_ff; end
         OP_AZ: begin mul_a = {16'd0, t_ff}; mul_b = {16'd0, in_ff.cmf_z}; acc_sel = acc_z_ff; end
         OP_LX: begin mul_a = {8'd0, acc_x_ff[23:0]}; mul_b = out_scale_ff; end
         OP_HX: begin mul_a = {8'd0, acc_x_ff[47:24]}; mul_b = out_scale_ff; end
         OP_LY: begin mul_a = {8'd0, acc_y_ff[23:0]}; mul_b = out_scale_ff; end
         OP_HY: begin mul_a = {8'd0, acc_y_ff[47:24]}; mul_b = out_scale_ff; end
         OP_LZ: begin mul_a = {8'd0, acc_z_ff[23:0]}; mul_b = out_scale_ff; end
         OP_HZ: begin mul_a = {8'd0, acc_z_ff[47:24]}; mul_b = out_scale_ff; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod   = mul_a * mul_b;
   assign prod_e = prod + 64'd2097152;
   assign e32    = prod_e[58:22];
   assign prod_g = prod + 64'd2147483648;
   assign prod_q = prod + 64'd536870912;

   assign sh     = 6'd14 + {1'b0, n_ff};
   assign t_sum  = {32'd0, e_ff} + (64'd1 << (sh - 6'd1));
   assign t_wide = t_sum >> sh;

   assign acc_sum = {1'b0, acc_sel} + {17'd0, prod[31:0]};

   assign p_full = {prod[55:0], 24'd0} + {24'd0, lo_ff} + 80'd536870912;
   assign r_out  = p_full[79:30];
   assign r_sat  = (r_out[49:32] != '0);
   assign r_val  = r_sat ? OUT_MAX : r_out[31:0];

   always_comb begin
      d_in = d_ff; n_in = n_ff; f_in = f_ff; flush_in = flush_ff;
      g_in = g_ff; q_in = q_ff; gg_in = gg_ff; e_in = e_ff; t_in = t_ff;
      acc_x_in = acc_x_ff; acc_y_in = acc_y_ff; acc_z_in = acc_z_ff;
      lo_in = lo_ff;
      ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      sx_in = sx_ff; sy_in = sy_ff; sz_in = sz_ff;
      case (cmd.op)
         OP_D0: d_in = prod[33:0];
         OP_D1, OP_D2: d_in = d_ff + prod[33:0];
         OP_D3: d_in = bl_en_ff ? d_ff + prod[33:0] : d_ff;
         OP_E: begin
            n_in     = e32[36:32];
            f_in     = e32[31:0];
            flush_in = (d_ff >= FLUSH_D);
         end
         OP_G:  g_in  = prod_g[62:32];
         OP_Q1: q_in  = C4_Q30 - prod_q[61:30];
         OP_Q2: q_in  = C3_Q30 - prod_q[61:30];
         OP_Q3: q_in  = C2_Q30 - prod_q[61:30];
         OP_GG: gg_in = prod_q[61:30];
         OP_EX: e_in  = Q30_ONE - {1'b0, g_ff} + prod_q[61:30];
         OP_T: begin
            if (flush_ff) begin
               t_in = '0;
            end else if (t_wide[63:16] != '0) begin
               t_in = T_MAX;
            end else begin
               t_in = t_wide[15:0];
            end
         end
         OP_AX: acc_x_in = acc_sum[48] ? ACC_MAX : acc_sum[47:0];
         OP_AY: acc_y_in = acc_sum[48] ? ACC_MAX : acc_sum[47:0];
         OP_AZ: acc_z_in = acc_sum[48] ? ACC_MAX : acc_sum[47:0];
         OP_LX, OP_LY, OP_LZ: lo_in = prod[55:0];
         OP_HX: begin ox_in = r_val; sx_in = r_sat; end
         OP_HY: begin oy_in = r_val; sy_in = r_sat; end
         OP_HZ: begin oz_in = r_val; sz_in = r_sat; end
         OP_EMIT: begin acc_x_in = '0; acc_y_in = '0; acc_z_in = '0; end
         default: d_in = d_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bl_en_ff     <= 1'b0;
         bl_scale_ff  <= BASELINE_SCALE_RESET;
         out_scale_ff <= OUTPUT_SCALE_RESET;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_z_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_BASELINE_ENABLE: bl_en_ff     <= csr_wdata[0];
               REG_BASELINE_SCALE:  bl_scale_ff  <= csr_wdata[15:0];
               REG_OUTPUT_SCALE:    out_scale_ff <= csr_wdata;
               default:             bl_en_ff     <= bl_en_ff;
            endcase
         end
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         acc_z_ff     <= acc_z_in;
         rsp_valid_ff <= (cmd.op == OP_EMIT) ? 1'b1 : (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         in_ff <= req_data;
      end
      if (cmd.op == OP_EMIT) begin
         rsp_ff <= '{x_out: ox_ff, y_out: oy_ff, z_out: oz_ff,
                     saturated: sx_ff | sy_ff | sz_ff};
      end
      d_ff <= d_in; n_ff <= n_in; f_ff <= f_in; flush_ff <= flush_in;
      g_ff <= g_in; q_ff <= q_in; gg_ff <= gg_in; e_ff <= e_in; t_ff <= t_in;
      lo_ff <= lo_in;
      ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
      sx_ff <= sx_in; sy_ff <= sy_in; sz_ff <= sz_in;
   end

   assign sts.last     = in_ff.last;
   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

`ifndef SYNTHESIS
   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |=> rsp_valid_ff)
      else $error("emit did not raise rsp_valid");
   a_emit_clears_acc: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |=> (acc_x_ff == '0 && acc_y_ff == '0 && acc_z_ff == '0))
      else $error("accumulators not cleared after result");
   a_flush_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_T && flush_ff) |=> (t_ff == '0))
      else $error("dense sample did not flush transmittance");
`endif

endmodule

/* hw/rtl/dye_transmittance_to_xyz_top.sv */
// Top level of the dye transmittance to XYZ block.
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_type sample beat
//  rsp     | out       | rsp_valid/rsp_stall | rsp_type tristimulus beat
//  csr     | in        | csr_we             | csr_addr, csr_wdata
// A sample steps from accept back to idle through the density, exponent and
// accumulate states on a single shared multiplier; a final sample adds six
// output-scaling steps and one to load the result register.
// Reset clears accumulators and the result valid and returns configuration to its reset values.
// A result waiting under rsp_stall does not block new samples; only the next
// final sample waits for the result register to drain.
module dye_transmittance_to_xyz_top import dtx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CFG_ADDR_W-1:0] csr_addr,
   input  logic [CFG_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   dtx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dtx_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* verif/tb_top.sv */
// Testbench for dye_transmittance_to_xyz_top: predicts XYZ per spectrum and checks each beat.
module tb_top;
   import dtx_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CFG_ADDR_W-1:0] csr_addr = '0;
   logic [CFG_DATA_W-1:0] csr_wdata = '0;

   dye_transmittance_to_xyz_top u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [47:0] sum_x, sum_y, sum_z;
   logic        base_en;
   logic [15:0] base_scale;
   logic [31:0] out_scale;

   req_type sample_q[$];
   rsp_type tristim_q[$];
   int      errors = 0;
   bit      hold_send = 1'b0;
   bit      quiet_rsp = 1'b0;
   longint  cycles = 0;

   function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b} + (128'd1 << 29);
      return p[93:30];
   endfunction

   function automatic logic [15:0] transmittance(logic [33:0] dens);
      logic [127:0] e32, w;
      logic [63:0]  n, f, g, q, e, sh, t;
      if (dens >= FLUSH_D) return 16'd0;
      e32 = ({94'd0, dens} * {96'd0, LOG2_10_Q30} + (128'd1 << 21)) >> 22;
      n = {32'd0, e32[63:32]};
      f = {32'd0, e32[31:0]};
      w = {64'd0, f} * {96'd0, LN2_Q30} + (128'd1 << 31);
      g = w[95:32];
      q = {32'd0, C4_Q30} - mul_q30({32'd0, C5_Q30}, g);
      q = {32'd0, C3_Q30} - mul_q30(q, g);
      q = {32'd0, C2_Q30} - mul_q30(q, g);
      e = {32'd0, Q30_ONE} - g + mul_q30(mul_q30(g, g), q);
      sh = 64'd14 + n;
      t = (e + (64'd1 << (sh - 64'd1))) >> sh;
      return (t > {48'd0, T_MAX}) ? T_MAX : t[15:0];
   endfunction

   function automatic logic [47:0] sat_add(logic [47:0] a, logic [31:0] v);
      logic [48:0] s;
      s = {1'b0, a} + {17'd0, v};
      return s[48] ? ACC_MAX : s[47:0];
   endfunction

   function automatic logic [31:0] scale_sum(logic [47:0] a, inout logic sat);
      logic [127:0] r;
      r = ({80'd0, a} * {96'd0, out_scale} + (128'd1 << 29)) >> 30;
      if (r > {96'd0, OUT_MAX}) begin
         sat = 1'b1;
         return OUT_MAX;
      end
      return r[31:0];
   endfunction

   task automatic integrate_sample(req_type s);
      logic [33:0] dens;
      logic [15:0] t;
      rsp_type     r;
      logic        sat;
      dens = {18'd0, s.density_y} * {18'd0, s.ext_y}
           + {18'd0, s.density_m} * {18'd0, s.ext_m}
           + {18'd0, s.density_c} * {18'd0, s.ext_c};
      if (base_en) dens = dens + {18'd0, base_scale} * {18'd0, s.baseline_density};
      t = transmittance(dens);
      sum_x = sat_add(sum_x, {16'd0, t} * {16'd0, s.cmf_x});
      sum_y = sat_add(sum_y, {16'd0, t} * {16'd0, s.cmf_y});
      sum_z = sat_add(sum_z, {16'd0, t} * {16'd0, s.cmf_z});
      if (s.last) begin
         sat = 1'b0;
         r.x_out = scale_sum(sum_x, sat);
         r.y_out = scale_sum(sum_y, sat);
         r.z_out = scale_sum(sum_z, sat);
         r.saturated = sat;
         tristim_q.push_back(r);
         sum_x = '0;
         sum_y = '0;
         sum_z = '0;
      end
   endtask

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         integrate_sample(req_data);
         send_gap = gap_len();
         if (sample_q.size() > 0 && send_gap == 0 && !hold_send) begin
            req_data <= sample_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (sample_q.size() > 0 && !hold_send) begin
            req_data <= sample_q.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // monitor
   int stall_left = 0;
   always @(posedge clock) begin
      rsp_type exp_r;
      cycles++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (tristim_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               errors++;
            end else begin
               exp_r = tristim_q.pop_front();
               if (exp_r.x_out !== rsp_data.x_out)
                  $display("%0t: x_out exp %h got %h", $time, exp_r.x_out, rsp_data.x_out);
               if (exp_r.y_out !== rsp_data.y_out)
                  $display("%0t: y_out exp %h got %h", $time, exp_r.y_out, rsp_data.y_out);
               if (exp_r.z_out !== rsp_data.z_out)
                  $display("%0t: z_out exp %h got %h", $time, exp_r.z_out, rsp_data.z_out);
               if (exp_r.saturated !== rsp_data.saturated)
                  $display("%0t: saturated exp %b got %b", $time, exp_r.saturated,
                           rsp_data.saturated);
               if (exp_r !== rsp_data) errors++;
            end
         end
         if (quiet_rsp) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = gap_len();
            rsp_stall <= (stall_left > 0);
         end
      end
      if (cycles > 2000000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_BASELINE_ENABLE: base_en = val[0];
         REG_BASELINE_SCALE:  base_scale = val[15:0];
         REG_OUTPUT_SCALE:    out_scale = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (sample_q.size() > 0 || req_valid || tristim_q.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic req_type rand_sample(int mode, bit is_last);
      req_type      s;
      logic [191:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      s = bits[160:0];
      if (mode == 0) begin
         // keep density modest so the dye sum alone stays below the flush threshold
         s.density_y = 16'($urandom_range(0, 4096));
         s.density_m = 16'($urandom_range(0, 4096));
         s.density_c = 16'($urandom_range(0, 4096));
         s.ext_y = 16'($urandom_range(0, 8191));
         s.ext_m = 16'($urandom_range(0, 8191));
         s.ext_c = 16'($urandom_range(0, 8191));
         s.baseline_density = 16'($urandom_range(0, 4096));
      end else if (mode == 1) begin
         s.density_y = 16'($urandom_range(0, 600));
         s.density_m = 16'($urandom_range(0, 600));
         s.density_c = 16'($urandom_range(0, 600));
         s.baseline_density = 16'($urandom_range(0, 600));
      end
      s.last = is_last;
      return s;
   endfunction

   task automatic random_spectra(int n_items);
      int len;
      int sent;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 128) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++)
            sample_q.push_back(rand_sample($urandom_range(0, 3), i == len - 1));
         sent += len;
      end
   endtask

   initial begin
      req_type s;
      sum_x = '0; sum_y = '0; sum_z = '0;
      base_en = 1'b0;
      base_scale = BASELINE_SCALE_RESET;
      out_scale = OUTPUT_SCALE_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero density, unity clamp, flush, field extremes
      s = '0; s.cmf_x = 16'hFFFF; s.cmf_y = 16'h4000; s.cmf_z = 16'h0001; s.last = 1'b1;
      sample_q.push_back(s);
      s = '1; s.last = 1'b1;
      sample_q.push_back(s);
      s = '0; s.density_y = 16'd4096; s.ext_y = 16'd24576; s.cmf_x = 16'hFFFF;
      s.cmf_y = 16'hFFFF; s.cmf_z = 16'hFFFF; s.last = 1'b1;
      sample_q.push_back(s);
      s.ext_y = 16'd24575;
      sample_q.push_back(s);
      s = '0; s.density_c = 16'd1; s.ext_c = 16'd1; s.cmf_x = 16'h8000;
      s.cmf_y = 16'h8000; s.cmf_z = 16'h8000; s.last = 1'b1;
      sample_q.push_back(s);
      for (int i = 0; i < 6; i++) begin
         s = rand_sample(0, i == 5);
         sample_q.push_back(s);
      end
      wait_drained();

      write_reg(REG_BASELINE_ENABLE, 32'd1);
      write_reg(REG_OUTPUT_SCALE, 32'hFFFF_FFFF);
      s = '0; s.baseline_density = 16'hFFFF; s.cmf_x = 16'hFFFF; s.last = 1'b1;
      sample_q.push_back(s);
      for (int i = 0; i < 4; i++) begin
         s = '0; s.cmf_x = 16'hFFFF; s.cmf_y = 16'hFFFF; s.cmf_z = 16'hFFFF;
         s.last = (i == 3);
         sample_q.push_back(s);
      end
      random_spectra(100);
      wait_drained();

      write_reg(REG_BASELINE_SCALE, 32'd0);
      write_reg(REG_OUTPUT_SCALE, 32'd0);
      random_spectra(100);
      wait_drained();

      write_reg(REG_BASELINE_SCALE, 32'hFFFF);
      write_reg(REG_OUTPUT_SCALE, $urandom);
      random_spectra(300);
      // sender holds off until all results are back
      hold_send = 1'b1;
      quiet_rsp = 1'b1;
      wait (sample_q.size() == 0 || !req_valid);
      while (req_valid || tristim_q.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
      hold_send = 1'b0;
      quiet_rsp = 1'b0;
      wait_drained();

      write_reg(REG_BASELINE_ENABLE, 32'd0);
      write_reg(REG_BASELINE_SCALE, $urandom_range(0, 16384));
      write_reg(REG_OUTPUT_SCALE, $urandom_range(1 << 20, 1 << 26));
      random_spectra(400);
      wait_drained();

      write_reg(REG_BASELINE_ENABLE, 32'd1);
      write_reg(REG_OUTPUT_SCALE, OUTPUT_SCALE_RESET);
      random_spectra(430);
      wait_drained();

      if (errors == 0 && tristim_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

/* dye_transmittance_to_xyz_top.f */
hw/rtl/dtx_pkg.sv
hw/rtl/dtx_ctrl.sv
hw/rtl/dtx_datapath.sv
hw/rtl/dye_transmittance_to_xyz_top.sv
verif/tb_top.sv
